@@ src/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/cdt_pkg.sv @@
`timescale 1ns / 1ps

package cdt_pkg;

  // command codes
  localparam logic [2:0] MODE_QUERY  = 3'd0;
  localparam logic [2:0] MODE_START  = 3'd1;
  localparam logic [2:0] MODE_PAUSE  = 3'd2;
  localparam logic [2:0] MODE_STOP   = 3'd3;
  localparam logic [2:0] MODE_EXTEND = 3'd4;
  localparam logic [2:0] MODE_ADD    = 3'd5;
  localparam logic [2:0] MODE_CHECK  = 3'd6;

  // reported state codes
  localparam logic [1:0] TS_IDLE  = 2'd0;
  localparam logic [1:0] TS_RUN   = 2'd1;
  localparam logic [1:0] TS_PAUSE = 2'd2;

  localparam int unsigned DUR_W = 24;
  localparam logic [DUR_W-1:0] DUR_RESET = 24'd60;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_PAUSE = 3'b100
  } run_state_t;

  typedef struct packed {
    run_state_t         run;
    logic signed [33:0] deadline;
    logic signed [31:0] remaining;
    logic               pend;
    logic               notif;
  } cdt_state_t;

  typedef struct packed {
    logic [1:0]         timer_state;
    logic signed [31:0] remaining;
    logic               overtime;
    logic               fired;
    logic               waiting;
  } cdt_result_t;

  // clamp a 35-bit value into the 34-bit signed range
  function automatic logic signed [33:0] sat34(input logic signed [34:0] v);
    logic signed [33:0] r;
    if (v[34] == v[33]) begin
      r = v[33:0];
    end else if (v[34]) begin
      r = {1'b1, 33'd0};
    end else begin
      r = {1'b0, {33{1'b1}}};
    end
    return r;
  endfunction

  // clamp a 35-bit value into the 32-bit signed range
  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111) begin
      r = v[31:0];
    end else if (v[34]) begin
      r = {1'b1, 31'd0};
    end else begin
      r = {1'b0, {31{1'b1}}};
    end
    return r;
  endfunction

endpackage

@@ src/cdt_cmd.sv @@
`timescale 1ns / 1ps

module cdt_cmd import cdt_pkg::*; (
  input  cdt_state_t         cur,
  input  logic [DUR_W-1:0]   duration,
  input  logic [2:0]         mode,
  input  logic [31:0]        now_seconds,
  input  logic signed [24:0] delta_seconds,
  output cdt_state_t         nxt,
  output cdt_result_t        res
);

  logic signed [34:0] now_s;
  logic signed [34:0] dur_s;
  logic signed [34:0] rem_s;
  logic signed [34:0] delta_s;
  logic signed [34:0] end_s;
  logic signed [34:0] start_span;
  logic signed [34:0] end_nxt_s;
  logic signed [34:0] end_add_s;
  logic signed [33:0] end_add;
  logic signed [31:0] rem_add;
  logic               rem_le0;
  logic               fired;

  // 35-bit operands: inputs zero-extended; remaining, delta and end time sign-extended
  assign now_s   = $signed({3'b000, now_seconds});
  assign dur_s   = $signed({11'd0, duration});
  assign rem_s   = {{3{cur.remaining[31]}}, cur.remaining};
  assign delta_s = {{10{delta_seconds[24]}}, delta_seconds};
  assign end_s   = {cur.deadline[33], cur.deadline};
  assign rem_le0 = cur.remaining[31] || (cur.remaining == 32'sd0);

  // span used by start
  always_comb begin
    if (cur.run == ST_RUN) begin
      start_span = dur_s;
    end else if (cur.run == ST_IDLE && rem_le0) begin
      start_span = dur_s;
    end else begin
      start_span = rem_s;
    end
  end

  // add results
  assign end_add   = sat34(end_s + delta_s);
  assign end_add_s = {end_add[33], end_add};
  assign rem_add   = sat32(rem_s + delta_s);

  // command decode
  always_comb begin
    nxt   = cur;
    fired = 1'b0;
    unique case (mode)
      MODE_START: begin
        nxt.deadline = sat34(now_s + start_span);
        nxt.run      = ST_RUN;
        nxt.pend     = 1'b0;
        nxt.notif    = 1'b0;
      end
      MODE_PAUSE: begin
        if (cur.run == ST_RUN) begin
          nxt.remaining = sat32(end_s - now_s);
        end
        nxt.run = ST_PAUSE;
      end
      MODE_STOP: begin
        nxt.run       = ST_IDLE;
        nxt.remaining = $signed({8'd0, duration});
        nxt.deadline  = 34'sd0;
        nxt.pend      = 1'b0;
        nxt.notif     = 1'b0;
      end
      MODE_EXTEND: begin
        nxt.run      = ST_RUN;
        nxt.deadline = sat34(now_s + delta_s);
        nxt.pend     = 1'b0;
        nxt.notif    = 1'b0;
      end
      MODE_ADD: begin
        if (cur.run == ST_RUN) begin
          nxt.deadline = end_add;
          // leaving overtime re-arms the alarm
          if (end_s <= now_s && end_add_s > now_s) begin
            nxt.pend  = 1'b0;
            nxt.notif = 1'b0;
          end
        end else if (cur.run == ST_PAUSE) begin
          nxt.remaining = rem_add;
          if (rem_le0 && !rem_add[31] && rem_add != 32'sd0) begin
            nxt.pend  = 1'b0;
            nxt.notif = 1'b0;
          end
        end
      end
      MODE_CHECK: begin
        if (cur.run == ST_RUN && end_s <= now_s && !cur.notif) begin
          nxt.pend  = 1'b1;
          nxt.notif = 1'b1;
          fired     = 1'b1;
        end
      end
      default: begin
        // query and the unused code leave the state alone
      end
    endcase
  end

  // result from the state after the command
  assign end_nxt_s = {nxt.deadline[33], nxt.deadline};

  always_comb begin
    unique case (nxt.run)
      ST_RUN:   res.timer_state = TS_RUN;
      ST_PAUSE: res.timer_state = TS_PAUSE;
      default:  res.timer_state = TS_IDLE;
    endcase
    res.remaining = (nxt.run == ST_RUN) ? sat32(end_nxt_s - now_s) : nxt.remaining;
    res.overtime  = (nxt.run == ST_RUN) && (end_nxt_s <= now_s);
    res.fired     = fired;
    res.waiting   = nxt.pend;
  end

endmodule

@@ src/countdown_timer_with_overtime.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Countdown timer with overtime, one command per item.
// Input channel: in_valid / in_stall with in_mode, in_now_seconds and
// in_delta_seconds; an item is taken at an edge where in_valid is high and
// in_stall is low. Every item gives exactly one result on the out_ channel
// (out_valid / out_stall), in order.
// Path: an accepted item is held in the input register, then the command
// logic writes the timer state and the result register together, which
// raises out_valid.
// Throughput: one item per cycle when not stalled; the timer state register
// is updated in the same cycle its result is registered, so the next item
// sees it at once. While out_stall holds a result, the input register still
// takes one more item; in_stall then rises until the result is taken.
// cfg_wr_en / cfg_wr_data write the duration and reload the remaining time;
// write only while no item is in flight.
// Reset (rst_n low, synchronous): timer idle, remaining and duration 60,
// end time 0, alarm flags clear, both pipeline registers empty.
module countdown_timer_with_overtime import cdt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_mode,
  input  logic [31:0]        in_now_seconds,
  input  logic signed [24:0] in_delta_seconds,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_timer_state,
  output logic signed [31:0] out_remaining_seconds,
  output logic               out_in_overtime,
  output logic               out_alarm_fired,
  output logic               out_alarm_waiting,
  input  logic               cfg_wr_en,
  input  logic [DUR_W-1:0]   cfg_wr_data
);

  logic               in_valid_r;
  logic [2:0]         in_mode_r;
  logic [31:0]        in_now_r;
  logic signed [24:0] in_delta_r;
  logic               out_valid_r;
  cdt_result_t        out_r;
  cdt_state_t         st_r;
  cdt_state_t         st_nxt;
  cdt_result_t        res_nxt;
  logic [DUR_W-1:0]   duration_r;
  logic               adv;

  // pipeline advance
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_mode_r  <= in_mode;
      in_now_r   <= in_now_seconds;
      in_delta_r <= in_delta_seconds;
    end
  end

  // command logic
  cdt_cmd u_cmd (
    .cur           (st_r),
    .duration      (duration_r),
    .mode          (in_mode_r),
    .now_seconds   (in_now_r),
    .delta_seconds (in_delta_r),
    .nxt           (st_nxt),
    .res           (res_nxt)
  );

  // timer state and duration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.run       <= ST_IDLE;
      st_r.deadline  <= 34'sd0;
      st_r.remaining <= $signed({8'd0, DUR_RESET});
      st_r.pend      <= 1'b0;
      st_r.notif     <= 1'b0;
      duration_r     <= DUR_RESET;
    end else if (cfg_wr_en) begin
      duration_r     <= cfg_wr_data;
      st_r.remaining <= $signed({8'd0, cfg_wr_data});
    end else if (adv && in_valid_r) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid_r) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_timer_state       = out_r.timer_state;
  assign out_remaining_seconds = out_r.remaining;
  assign out_in_overtime       = out_r.overtime;
  assign out_alarm_fired       = out_r.fired;
  assign out_alarm_waiting     = out_r.waiting;

  // checks
  `ASSERT_IMPLIES(a_fired_flags, clk, rst_n, out_valid && out_alarm_fired, out_alarm_waiting && out_in_overtime, "alarm fired without pending flag or overtime")
  `ASSERT_IMPLIES(a_overtime_running, clk, rst_n, out_valid && out_in_overtime, out_timer_state == TS_RUN, "overtime reported while not running")
  `ASSERT_IMPLIES(a_pend_notif, clk, rst_n, st_r.pend, st_r.notif, "alarm pending without notified flag")
  `ASSERT_NEXT(a_hold_result, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_r) && $stable(st_r.run), "stalled result or timer state changed")

endmodule
